@@ hw/rtl/bzs_pkg.sv @@
// Shared types and constants for the cubic Bezier point stepper.
`timescale 1ns / 1ps
package bzs_pkg;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned COUNT_W = 7;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned FRAC_W  = 16;
	localparam int unsigned MAG_W   = DATA_W + 1;

	typedef logic signed [DATA_W-1:0] q16_t;

	typedef struct packed {
		logic               last;
		logic [INDEX_W-1:0] index;
		q16_t               t;
	} side_t;
endpackage

@@ hw/rtl/cubic_bezier_point_stepper.sv @@
// Top level: request sequencer, parameter stepper and de Casteljau pipeline.
// Division runs first (skipped for one or zero points), then one point is
// issued per cycle; each point appears on result_strobe after the pipeline.
// A request of n points holds busy through division and its n issues (a
// zero-point request never raises busy); the 33-bit divider sets division time.
// Reset clears the sequencer and the pipeline valid bits; results cannot stall.
`timescale 1ns / 1ps
module cubic_bezier_point_stepper #(
	parameter int unsigned MAX_POINTS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bzs_pkg::COUNT_W-1:0]   point_count,
	input  bzs_pkg::q16_t                 param_begin,
	input  bzs_pkg::q16_t                 param_end,
	input  bzs_pkg::q16_t                 p0_x,
	input  bzs_pkg::q16_t                 p0_y,
	input  bzs_pkg::q16_t                 p1_x,
	input  bzs_pkg::q16_t                 p1_y,
	input  bzs_pkg::q16_t                 p2_x,
	input  bzs_pkg::q16_t                 p2_y,
	input  bzs_pkg::q16_t                 p3_x,
	input  bzs_pkg::q16_t                 p3_y,
	output logic                          result_strobe,
	output logic [bzs_pkg::INDEX_W-1:0]   step_index,
	output bzs_pkg::q16_t                 param_value,
	output bzs_pkg::q16_t                 point_x,
	output bzs_pkg::q16_t                 point_y,
	output logic                          last_point
);
	import bzs_pkg::*;

	localparam int unsigned DEPTH = 9;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t               state_q;
	logic [COUNT_W-1:0]   n_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [INDEX_W-1:0]   denom_q;
	q16_t                 begin_q;
	logic                 neg_q;
	logic [MAG_W-1:0]     span_mag;
	logic [MAG_W-1:0]     step_q_q;
	logic [INDEX_W-1:0]   step_r_q;
	logic [MAG_W-1:0]     accq_q;
	logic [INDEX_W:0]     accr_q;
	q16_t                 cx_q [4];
	q16_t                 cy_q [4];

	logic [COUNT_W-1:0]   n_clamp;
	logic signed [DATA_W:0] span;
	logic                 div_start;
	logic                 div_done;
	logic [MAG_W-1:0]     div_quo;
	logic [INDEX_W-1:0]   div_rem;
	logic [INDEX_W:0]     r_sum;
	logic                 r_wrap;
	logic signed [MAG_W:0] off;
	logic signed [MAG_W:0] t_full;
	logic                 issue;
	logic [DEPTH:0]       valid_s;
	side_t                pipe_s [DEPTH+1];

	q16_t ax, bx, cx, dx, ex, fx;
	q16_t ay, by, cy, dy, ey, fy;

	assign busy    = state_q != ST_IDLE;
	assign n_clamp = (point_count > COUNT_W'(MAX_POINTS)) ? COUNT_W'(MAX_POINTS) : point_count;
	assign span    = (DATA_W+1)'(param_end) - (DATA_W+1)'(param_begin);
	assign span_mag = span[DATA_W] ? MAG_W'(-span) : MAG_W'(span);
	assign div_start = start && !busy && (n_clamp > COUNT_W'(1));
	assign issue   = state_q == ST_EMIT;
	assign r_sum   = accr_q + {1'b0, step_r_q};
	assign r_wrap  = r_sum >= {1'b0, denom_q};
	assign off     = signed'({1'b0, accq_q});
	assign t_full  = (MAG_W+1)'(begin_q) + (neg_q ? -off : off);

	bzs_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (span_mag),
		.divisor   (INDEX_W'(n_clamp - 1'b1)),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (n_clamp == COUNT_W'(1))
							state_q <= ST_EMIT;
						else if (n_clamp != '0)
							state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (COUNT_W'(idx_q) == n_q - 1'b1)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			n_q      <= n_clamp;
			denom_q  <= INDEX_W'(n_clamp - 1'b1);
			begin_q  <= param_begin;
			neg_q    <= span[DATA_W];
			step_q_q <= '0;
			step_r_q <= '0;
			accq_q   <= '0;
			accr_q   <= '0;
			idx_q    <= '0;
			cx_q     <= '{p0_x, p1_x, p2_x, p3_x};
			cy_q     <= '{p0_y, p1_y, p2_y, p3_y};
		end else if (div_done) begin
			step_q_q <= div_quo;
			step_r_q <= div_rem;
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
			if (r_wrap) begin
				accr_q <= r_sum - {1'b0, denom_q};
				accq_q <= accq_q + step_q_q + 1'b1;
			end else begin
				accr_q <= r_sum;
				accq_q <= accq_q + step_q_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			valid_s <= {valid_s[DEPTH-1:0], issue};
		end
	end

	always_ff @(posedge clk) begin
		pipe_s[0].last  <= COUNT_W'(idx_q) == n_q - 1'b1;
		pipe_s[0].index <= idx_q;
		pipe_s[0].t     <= DATA_W'(t_full);
		for (int k = 1; k <= DEPTH; k++) begin
			pipe_s[k].last  <= pipe_s[k-1].last;
			pipe_s[k].index <= pipe_s[k-1].index;
			pipe_s[k].t     <= pipe_s[k-1].t;
		end
	end

	bzs_lerp u_ax (.clk(clk), .a(cx_q[0]), .b(cx_q[1]), .t(pipe_s[0].t), .res(ax));
	bzs_lerp u_bx (.clk(clk), .a(cx_q[1]), .b(cx_q[2]), .t(pipe_s[0].t), .res(bx));
	bzs_lerp u_cx (.clk(clk), .a(cx_q[2]), .b(cx_q[3]), .t(pipe_s[0].t), .res(cx));
	bzs_lerp u_dx (.clk(clk), .a(ax), .b(bx), .t(pipe_s[3].t), .res(dx));
	bzs_lerp u_ex (.clk(clk), .a(bx), .b(cx), .t(pipe_s[3].t), .res(ex));
	bzs_lerp u_fx (.clk(clk), .a(dx), .b(ex), .t(pipe_s[6].t), .res(fx));

	bzs_lerp u_ay (.clk(clk), .a(cy_q[0]), .b(cy_q[1]), .t(pipe_s[0].t), .res(ay));
	bzs_lerp u_by (.clk(clk), .a(cy_q[1]), .b(cy_q[2]), .t(pipe_s[0].t), .res(by));
	bzs_lerp u_cy (.clk(clk), .a(cy_q[2]), .b(cy_q[3]), .t(pipe_s[0].t), .res(cy));
	bzs_lerp u_dy (.clk(clk), .a(ay), .b(by), .t(pipe_s[3].t), .res(dy));
	bzs_lerp u_ey (.clk(clk), .a(by), .b(cy), .t(pipe_s[3].t), .res(ey));
	bzs_lerp u_fy (.clk(clk), .a(dy), .b(ey), .t(pipe_s[6].t), .res(fy));

	assign result_strobe = valid_s[DEPTH];
	assign step_index    = pipe_s[DEPTH].index;
	assign param_value   = pipe_s[DEPTH].t;
	assign last_point    = pipe_s[DEPTH].last;
	assign point_x       = fx;
	assign point_y       = fy;
endmodule

@@ hw/rtl/bzs_divider.sv @@
// Restoring divider: one quotient bit per cycle, magnitude of span by step count.
`timescale 1ns / 1ps
module bzs_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bzs_pkg::MAG_W-1:0]  dividend,
	input  logic [bzs_pkg::INDEX_W-1:0] divisor,
	output logic                       done,
	output logic [bzs_pkg::MAG_W-1:0]  quotient,
	output logic [bzs_pkg::INDEX_W-1:0] remainder
);
	import bzs_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAG_W + 1);

	logic                 run_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MAG_W-1:0]     quo_q;
	logic [INDEX_W-1:0]   rem_q;
	logic [INDEX_W-1:0]   div_q;
	logic [INDEX_W:0]     trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(MAG_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? INDEX_W'(trial - {1'b0, div_q}) : INDEX_W'(trial);
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

@@ hw/rtl/bzs_lerp.sv @@
// Three-stage Q16.16 interpolation a + round((b - a) * t), saturated.
`timescale 1ns / 1ps
module bzs_lerp (
	input  logic          clk,
	input  bzs_pkg::q16_t a,
	input  bzs_pkg::q16_t b,
	input  bzs_pkg::q16_t t,
	output bzs_pkg::q16_t res
);
	import bzs_pkg::*;

	localparam int unsigned PROD_W = 2 * DATA_W + 1;
	localparam int unsigned SUM_W  = PROD_W - FRAC_W + 2;

	logic signed [DATA_W:0]   d_s1;
	q16_t                     a_s1, t_s1, a_s2;
	logic signed [PROD_W-1:0] p_s2;
	logic signed [PROD_W:0]   rnd;
	logic signed [SUM_W-1:0]  sum;
	q16_t                     res_s3;

	assign rnd = (PROD_W+1)'(p_s2) + (PROD_W+1)'(signed'(1 << (FRAC_W - 1)));
	assign sum = SUM_W'(signed'(rnd[PROD_W:FRAC_W])) + SUM_W'(a_s2);

	always_ff @(posedge clk) begin
		d_s1   <= (DATA_W+1)'(b) - (DATA_W+1)'(a);
		a_s1   <= a;
		t_s1   <= t;
		p_s2   <= PROD_W'(d_s1) * PROD_W'(t_s1);
		a_s2   <= a_s1;
		if (sum > SUM_W'(signed'(32'sh7FFFFFFF)))
			res_s3 <= 32'sh7FFFFFFF;
		else if (sum < SUM_W'(signed'(32'sh80000000)))
			res_s3 <= 32'sh80000000;
		else
			res_s3 <= DATA_W'(sum);
	end

	assign res = res_s3;
endmodule
